// File: hdl/aar_pkg.sv
// Shared constants, types and a helper function for the axis-angle rotation matrix core.
package aar_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int TRIG_STAGES = 16;

  localparam int AXW    = 16;
  localparam int CW     = 34;
  localparam int ANG_W  = 34;
  localparam int PXW    = AXW + CW;
  localparam int QSHIFT = FRAC_BITS + 10;
  localparam int QX_W   = 37 - FRAC_BITS;
  localparam int QW     = (QX_W > 22) ? QX_W : 22;
  localparam int PW     = 2 * QW;
  localparam int NW     = PW + 2;
  localparam int RW     = NW + 1;
  localparam int DIV_STEPS = FRAC_BITS + 3;
  localparam int QDW    = DIV_STEPS;
  localparam int SAT_W  = QDW + 2;
  localparam int NENT   = 9;

  localparam logic signed [CW-1:0]    CORDIC_GAIN = CW'(652032874);
  localparam logic signed [ANG_W-1:0] DEG90       = ANG_W'(64'sd1509949440);
  localparam logic signed [ANG_W-1:0] DEG180      = ANG_W'(64'sd3019898880);

  localparam logic signed [ANG_W-1:0] ATAN_Q24 [32] = '{
    ANG_W'(754974720), ANG_W'(445687602), ANG_W'(235489088), ANG_W'(119537938),
    ANG_W'(60000934),  ANG_W'(30029717),  ANG_W'(15018523),  ANG_W'(7509720),
    ANG_W'(3754917),   ANG_W'(1877466),   ANG_W'(938734),    ANG_W'(469367),
    ANG_W'(234684),    ANG_W'(117342),    ANG_W'(58671),     ANG_W'(29335),
    ANG_W'(14668),     ANG_W'(7334),      ANG_W'(3667),      ANG_W'(1833),
    ANG_W'(917),       ANG_W'(458),       ANG_W'(229),       ANG_W'(115),
    ANG_W'(57),        ANG_W'(29),        ANG_W'(14),        ANG_W'(7),
    ANG_W'(4),         ANG_W'(2),         ANG_W'(1),         ANG_W'(0)
  };

  localparam logic signed [SAT_W-1:0] ONE     = SAT_W'(1) <<< FRAC_BITS;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-32768);

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
    logic signed [AXW-1:0]   ax;
    logic signed [AXW-1:0]   ay;
    logic signed [AXW-1:0]   az;
  } cordic_t;

  typedef struct packed {
    logic [NW-1:0]            den;
    logic [NENT-1:0][NW-1:0]  num;
  } ratio_in_t;

  typedef struct packed {
    logic                     zero;
    logic [NENT-1:0]          sgn;
    logic [NENT-1:0][QDW-1:0] quo;
  } quot_t;

  function automatic logic [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'h7fff;
    end else if (v < SAT_MIN) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/aar_if.sv
// Handshake interfaces for the input items and the matrix result items.
interface aar_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  angle_deg;
  logic signed [15:0]  axis_x;
  logic signed [15:0]  axis_y;
  logic signed [15:0]  axis_z;
  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aar_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  m_r0c0;
  logic signed [15:0]  m_r0c1;
  logic signed [15:0]  m_r0c2;
  logic signed [15:0]  m_r1c0;
  logic signed [15:0]  m_r1c1;
  logic signed [15:0]  m_r1c2;
  logic signed [15:0]  m_r2c0;
  logic signed [15:0]  m_r2c1;
  logic signed [15:0]  m_r2c2;
  logic                degenerate;
  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, degenerate, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                m_r2c0, m_r2c1, m_r2c2, degenerate, output ready);
endinterface

// File: hdl/aar_cordic.sv
// Pipelined rotation-mode CORDIC, one register stage per iteration.
module aar_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  aar_pkg::cordic_t din,
  output logic            vout,
  output aar_pkg::cordic_t dout
);
  aar_pkg::cordic_t st  [aar_pkg::TRIG_STAGES+1];
  logic             vld [aar_pkg::TRIG_STAGES+1];

  assign st[0]  = din;
  assign vld[0] = vin;

  for (genvar i = 0; i < aar_pkg::TRIG_STAGES; i++) begin : g_stage
    aar_pkg::cordic_t            nxt;
    logic signed [aar_pkg::CW-1:0] dx;
    logic signed [aar_pkg::CW-1:0] dy;

    always_comb begin
      dx  = st[i].y >>> i;
      dy  = st[i].x >>> i;
      nxt = st[i];
      if (!st[i].z[aar_pkg::ANG_W-1]) begin
        nxt.x = st[i].x - dx;
        nxt.y = st[i].y + dy;
        nxt.z = st[i].z - aar_pkg::ATAN_Q24[i];
      end else begin
        nxt.x = st[i].x + dx;
        nxt.y = st[i].y - dy;
        nxt.z = st[i].z + aar_pkg::ATAN_Q24[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign vout = vld[aar_pkg::TRIG_STAGES];
  assign dout = st[aar_pkg::TRIG_STAGES];
endmodule

// File: hdl/aar_quat.sv
// Quaternion formation, pairwise products and the matrix numerators and norm.
module aar_quat (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  aar_pkg::cordic_t   din,
  output logic               vout,
  output aar_pkg::ratio_in_t dout
);
  localparam int QW  = aar_pkg::QW;
  localparam int PW  = aar_pkg::PW;
  localparam int NW  = aar_pkg::NW;
  localparam int PXW = aar_pkg::PXW;
  localparam int CW  = aar_pkg::CW;

  logic [3:0] v;

  logic signed [CW-1:0]  s_n, c_n;
  logic signed [PXW-1:0] px, py, pz;
  logic signed [CW-1:0]  c1;

  logic signed [PXW-1:0] rx, ry, rz;
  logic signed [CW-1:0]  rc;
  logic signed [QW-1:0]  qx, qy, qz, qw;

  logic signed [PW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  logic signed [NW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

  always_comb begin
    s_n = din.flip ? -din.y : din.y;
    c_n = din.flip ? -din.x : din.x;
    rx  = px + (PXW'(1) <<< (aar_pkg::QSHIFT - 1));
    ry  = py + (PXW'(1) <<< (aar_pkg::QSHIFT - 1));
    rz  = pz + (PXW'(1) <<< (aar_pkg::QSHIFT - 1));
    rc  = c1 + CW'(512);
    exx = NW'(xx);
    eyy = NW'(yy);
    ezz = NW'(zz);
    eww = NW'(ww);
    exy = NW'(xy);
    exz = NW'(xz);
    eyz = NW'(yz);
    ewx = NW'(wx);
    ewy = NW'(wy);
    ewz = NW'(wz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], vin};
    end
    if (en) begin
      px <= din.ax * s_n;
      py <= din.ay * s_n;
      pz <= din.az * s_n;
      c1 <= c_n;

      qx <= QW'(rx >>> aar_pkg::QSHIFT);
      qy <= QW'(ry >>> aar_pkg::QSHIFT);
      qz <= QW'(rz >>> aar_pkg::QSHIFT);
      qw <= QW'(rc >>> 10);

      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      ww <= qw * qw;
      xy <= qx * qy;
      xz <= qx * qz;
      yz <= qy * qz;
      wx <= qw * qx;
      wy <= qw * qy;
      wz <= qw * qz;

      dout.den    <= exx + eyy + ezz + eww;
      dout.num[0] <= (eww + exx) <<< 1;
      dout.num[1] <= (exy + ewz) <<< 1;
      dout.num[2] <= (exz - ewy) <<< 1;
      dout.num[3] <= (exy - ewz) <<< 1;
      dout.num[4] <= (eww + eyy) <<< 1;
      dout.num[5] <= (eyz + ewx) <<< 1;
      dout.num[6] <= (exz + ewy) <<< 1;
      dout.num[7] <= (eyz - ewx) <<< 1;
      dout.num[8] <= (eww + ezz) <<< 1;
    end
  end

  assign vout = v[3];
endmodule

// File: hdl/aar_div.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module aar_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  aar_pkg::ratio_in_t din,
  output logic               vout,
  output aar_pkg::quot_t     dout
);
  localparam int NW    = aar_pkg::NW;
  localparam int RW    = aar_pkg::RW;
  localparam int QDW   = aar_pkg::QDW;
  localparam int NENT  = aar_pkg::NENT;
  localparam int STEPS = aar_pkg::DIV_STEPS;

  typedef struct packed {
    logic                     zero;
    logic [NW-1:0]            den;
    logic [NENT-1:0]          sgn;
    logic [NENT-1:0][RW-1:0]  rem;
    logic [NENT-1:0][QDW-1:0] quo;
  } div_t;

  div_t st  [STEPS+1];
  logic vld [STEPS+1];
  div_t st0_next;
  logic [NW-1:0] neg_num;

  always_comb begin
    st0_next.zero = (din.den == '0);
    st0_next.den  = din.den;
    neg_num       = '0;
    for (int j = 0; j < NENT; j++) begin
      neg_num         = -din.num[j];
      st0_next.sgn[j] = din.num[j][NW-1];
      st0_next.rem[j] = din.num[j][NW-1] ? {1'b0, neg_num} : {1'b0, din.num[j]};
      st0_next.quo[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vin;
    end
    if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    div_t          nxt;
    logic [RW-1:0] cmp;
    logic [RW-1:0] rin;

    always_comb begin
      nxt = st[k];
      if (k < 2) begin
        cmp = RW'(st[k].den) << (1 - k);
      end else begin
        cmp = RW'(st[k].den);
      end
      for (int j = 0; j < NENT; j++) begin
        if (k < 2) begin
          rin = st[k].rem[j];
        end else begin
          rin = st[k].rem[j] << 1;
        end
        if (rin >= cmp) begin
          nxt.rem[j] = rin - cmp;
          nxt.quo[j] = {st[k].quo[j][QDW-2:0], 1'b1};
        end else begin
          nxt.rem[j] = rin;
          nxt.quo[j] = {st[k].quo[j][QDW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign vout      = vld[STEPS];
  assign dout.zero = st[STEPS].zero;
  assign dout.sgn  = st[STEPS].sgn;
  assign dout.quo  = st[STEPS].quo;
endmodule

// File: hdl/axis_angle_rotation_matrix_core.sv
// Axis-angle to rotation matrix core: half-angle CORDIC, quaternion, normalizing divide.
// Throughput is one item per cycle; the whole pipeline holds while a result waits.
// The 16-stage CORDIC and the 17-stage divider set the depth of the pipeline.
// Synchronous reset clears every valid bit; data registers are not reset.
module axis_angle_rotation_matrix_core (
  input logic        clk,
  input logic        rst,
  aar_in_if.sink     in_ch,
  aar_out_if.source  out_ch
);
  localparam int SAT_W = aar_pkg::SAT_W;
  localparam int QDW   = aar_pkg::QDW;

  logic en;

  logic signed [aar_pkg::ANG_W-1:0] z_in;
  aar_pkg::cordic_t                 s0, s0_next;
  logic                             v0;

  aar_pkg::cordic_t   cor_out;
  logic               cor_v;
  aar_pkg::ratio_in_t rat;
  logic               rat_v;
  aar_pkg::quot_t     quo;
  logic               quo_v;

  logic [QDW:0]             qr [aar_pkg::NENT];
  logic signed [SAT_W-1:0]  val [aar_pkg::NENT];
  logic [15:0]              ent [aar_pkg::NENT];

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    z_in = {in_ch.angle_deg[15], in_ch.angle_deg, 17'b0};
    s0_next.x    = aar_pkg::CORDIC_GAIN;
    s0_next.y    = '0;
    s0_next.z    = z_in;
    s0_next.flip = 1'b0;
    if (z_in > aar_pkg::DEG90) begin
      s0_next.z    = z_in - aar_pkg::DEG180;
      s0_next.flip = 1'b1;
    end else if (z_in < -aar_pkg::DEG90) begin
      s0_next.z    = z_in + aar_pkg::DEG180;
      s0_next.flip = 1'b1;
    end
    s0_next.ax = in_ch.axis_x;
    s0_next.ay = in_ch.axis_y;
    s0_next.az = in_ch.axis_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
    end
    if (en) begin
      s0 <= s0_next;
    end
  end

  aar_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v0),
    .din  (s0),
    .vout (cor_v),
    .dout (cor_out)
  );

  aar_quat u_quat (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (cor_v),
    .din  (cor_out),
    .vout (rat_v),
    .dout (rat)
  );

  aar_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (rat_v),
    .din  (rat),
    .vout (quo_v),
    .dout (quo)
  );

  always_comb begin
    for (int j = 0; j < aar_pkg::NENT; j++) begin
      qr[j]  = ((QDW+1)'(quo.quo[j]) + (QDW+1)'(1)) >> 1;
      val[j] = quo.sgn[j] ? -SAT_W'(qr[j]) : SAT_W'(qr[j]);
      if (j == 0 || j == 4 || j == 8) begin
        val[j] = val[j] - aar_pkg::ONE;
        if (quo.zero) begin
          val[j] = aar_pkg::ONE;
        end
      end else if (quo.zero) begin
        val[j] = '0;
      end
      ent[j] = aar_pkg::sat16(val[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= quo_v;
    end
    if (en) begin
      out_ch.m_r0c0     <= ent[0];
      out_ch.m_r0c1     <= ent[1];
      out_ch.m_r0c2     <= ent[2];
      out_ch.m_r1c0     <= ent[3];
      out_ch.m_r1c1     <= ent[4];
      out_ch.m_r1c2     <= ent[5];
      out_ch.m_r2c0     <= ent[6];
      out_ch.m_r2c1     <= ent[7];
      out_ch.m_r2c2     <= ent[8];
      out_ch.degenerate <= quo.zero;
    end
  end

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while a result item is stalled");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result item presented right after reset");

  a_degenerate_identity : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.degenerate |->
      out_ch.m_r0c1 == 16'sd0 && out_ch.m_r1c2 == 16'sd0 && out_ch.m_r2c0 == 16'sd0 &&
      out_ch.m_r0c0 == out_ch.m_r1c1 && out_ch.m_r1c1 == out_ch.m_r2c2)
    else $error("degenerate item is not the identity matrix");
endmodule
